// ===== design/tvsq_pkg.sv =====
// Package for the two-voice square tone generator.
// Holds the shared constants, the input kind codes and the voice control/status structs.
// No dependencies.
package tvsq_pkg;

  // Field widths
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int AMP_W    = 14;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 16;
  localparam int COUNT_W  = 22;

  // Defaults for the top-level parameters
  localparam int VOICES_DEF      = 2;
  localparam int SAMPLE_RATE_DEF = 48000;

  // Reset amplitude
  localparam logic [AMP_W-1:0] AMPLITUDE_RESET = AMP_W'(15000);

  // Duration scaling: count = (dur * SR) / MS_PER_SECOND.
  // Done as one multiply by ceil(SR * 2^DUR_FRAC_BITS / MS_PER_SECOND).
  // This is exact because 2^DUR_FRAC_BITS > 65535 * MS_PER_SECOND.
  localparam int MS_PER_SECOND = 1000;
  localparam int DUR_FRAC_BITS = 26;
  localparam int DUR_MULT_W    = 32;

  // APB
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_AMPLITUDE_IDX = 1'b0;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_PLAY = 1'b1
  } tvsq_kind_e;

  typedef struct packed {
    logic load;  // load new step/count, clear phase
    logic tick;  // advance one sample
  } tvsq_voice_ctrl_t;

  typedef struct packed {
    logic active;    // samples left
    logic negative;  // phase is in the negative half
  } tvsq_voice_stat_t;

endpackage

// ===== design/tvsq_voice.sv =====
// One voice of the tone generator: phase accumulator, step and sample countdown.
// Depends on tvsq_pkg.
module tvsq_voice #(
  parameter int SAMPLE_RATE = tvsq_pkg::SAMPLE_RATE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tvsq_pkg::tvsq_voice_ctrl_t      ctrl_i,
  input  logic [tvsq_pkg::PHASE_W-1:0]    step_i,
  input  logic [tvsq_pkg::COUNT_W-1:0]    count_i,
  output tvsq_pkg::tvsq_voice_stat_t      stat_o
);
  import tvsq_pkg::*;

  localparam logic [PHASE_W:0] SR_EXT = (PHASE_W+1)'(SAMPLE_RATE);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W-1:0] step_q, step_d;
  logic [COUNT_W-1:0] remaining_q, remaining_d;
  logic [PHASE_W:0]   phase_sum;

  assign stat_o.active   = (remaining_q != '0);
  assign stat_o.negative = ({phase_q, 1'b0} > SR_EXT);

  assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    remaining_d = remaining_q;
    if (ctrl_i.load) begin
      phase_d     = '0;
      step_d      = step_i;
      remaining_d = count_i;
    end else if (ctrl_i.tick && stat_o.active) begin
      remaining_d = remaining_q - COUNT_W'(1);
      if (phase_sum >= SR_EXT) begin
        phase_d = PHASE_W'(phase_sum - SR_EXT);
      end else begin
        phase_d = phase_sum[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      step_q      <= '0;
      remaining_q <= '0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      remaining_q <= remaining_d;
    end
  end

`ifndef SYNTHESIS
  // phase wraps below the sample rate
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, phase_q} < SR_EXT)
    else $error("voice phase out of range");

  // load restarts the phase
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |=> (phase_q == '0))
    else $error("voice phase not cleared on load");

  // an idle voice keeps its phase on a tick
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.tick && !ctrl_i.load && !stat_o.active) |=> $stable(phase_q))
    else $error("idle voice phase moved");
`endif

endmodule

// ===== design/two_voice_square_tone_generator_unit.sv =====
// Top level of the two-voice square tone generator.
// Depends on tvsq_pkg and tvsq_voice.

// Square-wave tone generator with VOICES voices, each a phase accumulator
// running modulo SAMPLE_RATE. A play transaction (kind 1) loads the next voice,
// in round-robin order, with its tone frequency and a sample count of
// duration_ms * SAMPLE_RATE / 1000, and clears its phase; it produces no
// output transaction. A tick transaction (kind 0) produces one signed sample:
// every voice with samples left adds -amplitude when twice its phase exceeds
// SAMPLE_RATE and +amplitude otherwise, counts down by one and advances its
// phase by its frequency modulo SAMPLE_RATE. The sum saturates to 16 bits.
// Rate: one input transaction per clock while the input is not stalled. An
// accepted transaction is held in the input register; when it leaves, the voices
// are updated and, for a tick, the sample is loaded into the output register, so
// a sample is offered in the cycle after its tick leaves the input register. The
// duration multiply, the frequency modulo and the mixer are combinational
// between the input register and the voice/output registers. The output
// register lets the input side keep moving while a sample waits; only a tick
// that finds the output register full and stalled holds the input.
// amplitude is register 0 of the APB port (byte address 0, 14 bits, reset 15000).
module two_voice_square_tone_generator_unit #(
  parameter int VOICES      = tvsq_pkg::VOICES_DEF,
  parameter int SAMPLE_RATE = tvsq_pkg::SAMPLE_RATE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [tvsq_pkg::FREQ_W-1:0]         tone_frequency_i,
  input  logic [tvsq_pkg::DUR_W-1:0]          duration_ms_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tvsq_pkg::SAMPLE_W-1:0] sample_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tvsq_pkg::PADDR_W-1:0]        paddr,
  input  logic [tvsq_pkg::PDATA_W-1:0]        pwdata,
  output logic [tvsq_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import tvsq_pkg::*;

  localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MIX_W    = AMP_W + 2 + VW;
  localparam int MOD_STEPS = $clog2((65535 / SAMPLE_RATE) + 1);
  localparam int PROD_W   = DUR_W + DUR_MULT_W;
  localparam logic [DUR_MULT_W-1:0] DUR_MULT = DUR_MULT_W'(
    (64'(SAMPLE_RATE) * (64'(1) << DUR_FRAC_BITS) + 64'(MS_PER_SECOND - 1))
    / 64'(MS_PER_SECOND));
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);
  localparam logic signed [MIX_W-1:0] SAMPLE_MAX = MIX_W'(32767);
  localparam logic signed [MIX_W-1:0] SAMPLE_MIN = -MIX_W'(32768);

  // ---------------- configuration ----------------
  logic [AMP_W-1:0] amplitude_q, amplitude_d;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_AMPLITUDE_IDX);

  always_comb begin
    amplitude_d = amplitude_q;
    if (cfg_write) begin
      amplitude_d = pwdata[AMP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_AMPLITUDE_IDX) begin
      prdata = PDATA_W'(amplitude_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q <= AMPLITUDE_RESET;
    end else begin
      amplitude_q <= amplitude_d;
    end
  end

  // ---------------- input register ----------------
  logic              s1_valid_q, s1_valid_d;
  tvsq_kind_e        s1_kind_q;
  logic [FREQ_W-1:0] s1_freq_q;
  logic [DUR_W-1:0]  s1_dur_q;
  logic              in_fire;
  logic              advance;
  logic              tick_fire;
  logic              play_fire;
  logic              out_valid_q, out_valid_d;

  // a play never needs the output register; a tick needs it free or draining
  assign advance   = s1_valid_q &&
                     ((s1_kind_q == KIND_PLAY) || !out_valid_q || !out_stall_i);
  assign tick_fire = advance && (s1_kind_q == KIND_TICK);
  assign play_fire = advance && (s1_kind_q == KIND_PLAY);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= tvsq_kind_e'(kind_i);
      s1_freq_q <= tone_frequency_i;
      s1_dur_q  <= duration_ms_i;
    end
  end

  // ---------------- play: step and sample count ----------------
  logic [PROD_W-1:0]  dur_prod;
  logic [COUNT_W-1:0] load_count;
  logic [FREQ_W:0]    mod_rem;
  logic [PHASE_W-1:0] load_step;

  assign dur_prod   = PROD_W'(s1_dur_q) * PROD_W'(DUR_MULT);
  // 22-bit wrap of the count
  assign load_count = dur_prod[DUR_FRAC_BITS +: COUNT_W];

  // frequency modulo SAMPLE_RATE by restoring subtraction, quotient < 2^MOD_STEPS
  always_comb begin
    mod_rem = {1'b0, s1_freq_q};
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      if (mod_rem >= (FREQ_W+1)'(SAMPLE_RATE << j)) begin
        mod_rem = mod_rem - (FREQ_W+1)'(SAMPLE_RATE << j);
      end
    end
  end
  assign load_step = mod_rem[PHASE_W-1:0];

  // ---------------- round-robin voice pointer ----------------
  logic [VW-1:0] next_voice_q, next_voice_d;

  always_comb begin
    next_voice_d = next_voice_q;
    if (play_fire) begin
      if (next_voice_q == LAST_VOICE) begin
        next_voice_d = '0;
      end else begin
        next_voice_d = next_voice_q + VW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_voice_q <= '0;
    end else begin
      next_voice_q <= next_voice_d;
    end
  end

  // ---------------- voices ----------------
  tvsq_voice_ctrl_t voice_ctrl [VOICES];
  tvsq_voice_stat_t voice_stat [VOICES];

  for (genvar v = 0; v < VOICES; v++) begin : g_voice
    assign voice_ctrl[v].load = play_fire && (next_voice_q == VW'(v));
    assign voice_ctrl[v].tick = tick_fire;

    tvsq_voice #(
      .SAMPLE_RATE(SAMPLE_RATE)
    ) u_voice (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (voice_ctrl[v]),
      .step_i (load_step),
      .count_i(load_count),
      .stat_o (voice_stat[v])
    );
  end

  // ---------------- mixer ----------------
  logic signed [MIX_W-1:0]    mix;
  logic signed [MIX_W-1:0]    amp_ext;
  logic signed [SAMPLE_W-1:0] mix_sat;

  assign amp_ext = $signed(MIX_W'(amplitude_q));

  always_comb begin
    mix = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (voice_stat[v].active) begin
        if (voice_stat[v].negative) begin
          mix = mix - amp_ext;
        end else begin
          mix = mix + amp_ext;
        end
      end
    end
  end

  always_comb begin
    priority if (mix > SAMPLE_MAX) begin
      mix_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (mix < SAMPLE_MIN) begin
      mix_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      mix_sat = mix[SAMPLE_W-1:0];
    end
  end

  // ---------------- output register ----------------
  logic signed [SAMPLE_W-1:0] sample_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      sample_q <= mix_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // flat view of the load strobes
  logic [VOICES-1:0] voice_ctrl_load_vec;
  for (genvar v = 0; v < VOICES; v++) begin : g_load_vec
    assign voice_ctrl_load_vec[v] = voice_ctrl[v].load;
  end

`ifndef SYNTHESIS
  // a new sample only follows a tick leaving the input register
  a_sample_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && (s1_kind_q == KIND_TICK)))
    else $error("sample without tick");

  // a play transaction never produces a sample
  a_play_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (play_fire && !out_valid_q) |=> !out_valid_q)
    else $error("play produced a sample");

  // input held only when a transaction is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

  // round-robin pointer stays in range
  a_voice_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_voice_q <= LAST_VOICE)
    else $error("voice pointer out of range");

  // exactly one voice loads on a play
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_fire |-> $onehot(voice_ctrl_load_vec))
    else $error("play did not load exactly one voice");
`endif

endmodule
